[rtl/brs_pkg.sv]
`default_nettype none

package brs_pkg;

  // Fixed field widths of the command and result channels
  localparam int CMD_W      = 2;
  localparam int HANDLE_W   = 16;
  localparam int FIELD_IVL_W = 16;
  localparam int SLOT_W     = 4;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int RETRY_W    = 5;
  localparam int TALLY_W    = 5;
  localparam int SECONDS_W  = 32;

  localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

  // Defaults for the top-level parameters
  localparam int ENTRIES_DEF       = 16;
  localparam int INTERVAL_BITS_DEF = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD_REPLY    = 3'd0,
    KIND_REMOVE_REPLY = 3'd1,
    KIND_RESEND       = 3'd2,
    KIND_TICK_DONE    = 3'd3,
    KIND_CLEAR_REPLY  = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_BAD_INTERVAL = 2'd1,
    ST_TABLE_FULL   = 2'd2,
    ST_SLOT_EMPTY   = 2'd3
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;     // input beat taken this cycle
    logic scanning;   // slot scan in progress
    logic step;       // commit the current slot and move to the next
    logic add_found;  // add lands in the current slot
    logic reply;      // load the final result
  } brs_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_e cmd;        // command being worked on
    logic in_direct;  // incoming command needs no scan
    logic slot_free;  // current slot is empty
    logic need_emit;  // current slot resends on this tick
    logic idx_last;   // current slot is the highest one
    logic can_emit;   // output register can take a beat
  } brs_stat_t;

endpackage

`default_nettype wire

[rtl/brs_ram.sv]
`default_nettype none

module brs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/brs_datapath.sv]
`default_nettype none

module brs_datapath #(
  parameter int ENTRIES       = brs_pkg::ENTRIES_DEF,
  parameter int INTERVAL_BITS = brs_pkg::INTERVAL_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [brs_pkg::CMD_W-1:0]        cmd_i,
  input  wire logic [brs_pkg::HANDLE_W-1:0]     message_handle_i,
  input  wire logic [brs_pkg::FIELD_IVL_W-1:0]  start_interval_i,
  input  wire logic [brs_pkg::FIELD_IVL_W-1:0]  interval_limit_i,
  input  wire logic [brs_pkg::SLOT_W-1:0]       target_slot_i,
  input  wire brs_pkg::brs_ctl_t                ctl_i,
  output      brs_pkg::brs_stat_t               stat_o,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic [brs_pkg::KIND_W-1:0]       kind_o,
  output      logic [brs_pkg::STATUS_W-1:0]     status_o,
  output      logic [brs_pkg::SLOT_W-1:0]       slot_o,
  output      logic [brs_pkg::HANDLE_W-1:0]     resend_handle_o,
  output      logic [brs_pkg::RETRY_W-1:0]      retry_number_o,
  output      logic                             retired_o,
  output      logic [brs_pkg::TALLY_W-1:0]      tally_o,
  output      logic                             last_o
);

  import brs_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  typedef struct packed {
    logic [HANDLE_W-1:0]      handle;
    logic [INTERVAL_BITS-1:0] ivl;
    logic [INTERVAL_BITS-1:0] lim;
    logic [SECONDS_W-1:0]     last_send;
    logic [RETRY_W-1:0]       retries;
  } entry_t;

  // Captured command
  cmd_e                     cmd_q;
  logic [HANDLE_W-1:0]      handle_q;
  logic [INTERVAL_BITS-1:0] ivl_q;
  logic [INTERVAL_BITS-1:0] lim_q;
  logic [SLOT_W-1:0]        target_q;
  logic                     bad_q;
  logic                     found_q;

  // Scan and time state
  logic [IDX_W-1:0]         idx_q;
  logic [TALLY_W-1:0]       tally_q;
  logic [SECONDS_W-1:0]     seconds_q;
  logic [ENTRIES-1:0]       valid_q;

  // Output register
  logic                     out_valid_q;
  kind_e                    out_kind_q;
  status_e                  out_status_q;
  logic [SLOT_W-1:0]        out_slot_q;
  logic [HANDLE_W-1:0]      out_handle_q;
  logic [RETRY_W-1:0]       out_retry_q;
  logic                     out_retired_q;
  logic [TALLY_W-1:0]       out_tally_q;
  logic                     out_last_q;

  // Incoming add check
  logic [INTERVAL_BITS-1:0] ivl_in;
  logic [INTERVAL_BITS-1:0] lim_in;
  logic                     in_bad;

  assign ivl_in = INTERVAL_BITS'(start_interval_i);
  assign lim_in = INTERVAL_BITS'(interval_limit_i);
  assign in_bad = (ivl_in == '0) || ({ivl_in, 1'b0} > {1'b0, lim_in});

  // Slot table
  entry_t           rd_entry;
  entry_t           wr_entry;
  entry_t           upd_entry;
  entry_t           new_entry;
  logic             ram_we;
  logic [IDX_W-1:0] raddr;

  always_comb begin
    if (ctl_i.step) begin
      raddr = idx_q + 1'b1;
    end else if (ctl_i.scanning) begin
      raddr = idx_q;
    end else begin
      raddr = '0;
    end
  end

  brs_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(wr_entry),
    .raddr_i(raddr),
    .rdata_o(rd_entry)
  );

  // Expiry and backoff for the slot under the scan
  logic [SECONDS_W-1:0] elapsed;
  logic                 expired;
  logic                 retire;
  logic                 need_emit;
  logic [RETRY_W-1:0]   retry_next;

  assign elapsed    = seconds_q - rd_entry.last_send;
  assign expired    = elapsed > SECONDS_W'(rd_entry.ivl);
  assign retire     = {rd_entry.ivl, 1'b0} > {1'b0, rd_entry.lim};
  assign need_emit  = (cmd_q == CMD_TICK) && valid_q[idx_q] && expired;
  assign retry_next = (rd_entry.retries == RETRY_MAX) ? rd_entry.retries
                                                       : rd_entry.retries + 1'b1;

  always_comb begin
    upd_entry           = rd_entry;
    upd_entry.last_send = seconds_q;
    upd_entry.retries   = retry_next;
    if (!retire) begin
      upd_entry.ivl = {rd_entry.ivl[INTERVAL_BITS-2:0], 1'b0};
    end
  end

  assign new_entry = '{handle: handle_q, ivl: ivl_q, lim: lim_q,
                       last_send: seconds_q, retries: '0};

  assign ram_we   = ctl_i.add_found || (ctl_i.step && need_emit);
  assign wr_entry = ctl_i.add_found ? new_entry : upd_entry;

  // Remove lookup
  logic             target_in_range;
  logic [IDX_W-1:0] target_idx;
  logic             remove_ok;

  assign target_in_range = 32'(target_q) < ENTRIES;
  assign target_idx      = IDX_W'(target_q);
  assign remove_ok       = target_in_range && valid_q[target_idx];

  // Final result of the command
  kind_e              fin_kind;
  status_e            fin_status;
  logic [SLOT_W-1:0]  fin_slot;
  logic [TALLY_W-1:0] fin_tally;

  always_comb begin
    fin_kind   = KIND_CLEAR_REPLY;
    fin_status = ST_OK;
    fin_slot   = '0;
    fin_tally  = tally_q;
    case (cmd_q)
      CMD_ADD: begin
        fin_kind  = KIND_ADD_REPLY;
        fin_tally = '0;
        if (bad_q) begin
          fin_status = ST_BAD_INTERVAL;
        end else if (found_q) begin
          fin_slot = SLOT_W'(idx_q);
        end else begin
          fin_status = ST_TABLE_FULL;
        end
      end
      CMD_REMOVE: begin
        fin_kind   = KIND_REMOVE_REPLY;
        fin_status = remove_ok ? ST_OK : ST_SLOT_EMPTY;
        fin_tally  = remove_ok ? TALLY_W'(1) : '0;
      end
      CMD_TICK: begin
        fin_kind = KIND_TICK_DONE;
      end
      default: begin
        fin_kind = KIND_CLEAR_REPLY;
      end
    endcase
  end

  // Command capture, scan index, tally and seconds counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= CMD_ADD;
      bad_q     <= 1'b0;
      found_q   <= 1'b0;
      idx_q     <= '0;
      tally_q   <= '0;
      seconds_q <= '0;
    end else begin
      if (ctl_i.accept) begin
        cmd_q   <= cmd_e'(cmd_i);
        bad_q   <= in_bad;
        found_q <= 1'b0;
        idx_q   <= '0;
        tally_q <= '0;
        if (cmd_e'(cmd_i) == CMD_TICK) begin
          seconds_q <= seconds_q + 1'b1;
        end
      end
      if (ctl_i.add_found) begin
        found_q <= 1'b1;
      end
      if (ctl_i.step) begin
        idx_q <= idx_q + 1'b1;
        if (need_emit || (cmd_q == CMD_CLEAR && valid_q[idx_q])) begin
          tally_q <= tally_q + 1'b1;
        end
      end
    end
  end

  // Payload of the command, no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      handle_q <= message_handle_i;
      ivl_q    <= ivl_in;
      lim_q    <= lim_in;
      target_q <= target_slot_i;
    end
  end

  // Slot occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ctl_i.add_found) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (ctl_i.step && need_emit && retire) begin
        valid_q[idx_q] <= 1'b0;
      end
      if (ctl_i.step && cmd_q == CMD_CLEAR) begin
        valid_q[idx_q] <= 1'b0;
      end
      if (ctl_i.reply && cmd_q == CMD_REMOVE && remove_ok) begin
        valid_q[target_idx] <= 1'b0;
      end
    end
  end

  // Output register
  logic can_emit;
  logic load_resend;

  assign can_emit    = !out_valid_q || !out_stall_i;
  assign load_resend = ctl_i.step && need_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_resend || ctl_i.reply) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_resend) begin
      out_kind_q    <= KIND_RESEND;
      out_status_q  <= ST_OK;
      out_slot_q    <= SLOT_W'(idx_q);
      out_handle_q  <= rd_entry.handle;
      out_retry_q   <= retry_next;
      out_retired_q <= retire;
      out_tally_q   <= '0;
      out_last_q    <= 1'b0;
    end else if (ctl_i.reply) begin
      out_kind_q    <= fin_kind;
      out_status_q  <= fin_status;
      out_slot_q    <= fin_slot;
      out_handle_q  <= '0;
      out_retry_q   <= '0;
      out_retired_q <= 1'b0;
      out_tally_q   <= fin_tally;
      out_last_q    <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_kind_q;
  assign status_o        = out_status_q;
  assign slot_o          = out_slot_q;
  assign resend_handle_o = out_handle_q;
  assign retry_number_o  = out_retry_q;
  assign retired_o       = out_retired_q;
  assign tally_o         = out_tally_q;
  assign last_o          = out_last_q;

  // Status to the controller
  assign stat_o.cmd       = cmd_q;
  assign stat_o.in_direct = (cmd_e'(cmd_i) == CMD_REMOVE)
                          || ((cmd_e'(cmd_i) == CMD_ADD) && in_bad);
  assign stat_o.slot_free = !valid_q[idx_q];
  assign stat_o.need_emit = need_emit;
  assign stat_o.idx_last  = (idx_q == IDX_LAST);
  assign stat_o.can_emit  = can_emit;

  // Add never overwrites a live slot
  a_add_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.add_found |-> !valid_q[idx_q])
    else $error("add placed into an occupied slot");

  // The closing beat of a command carries last
  a_reply_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.reply |=> out_valid_q && out_last_q)
    else $error("final beat not flagged last");

  // Time only moves on an accepted tick
  a_seconds_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.accept && cmd_e'(cmd_i) == CMD_TICK) |=> $stable(seconds_q))
    else $error("seconds counter moved without a tick");

endmodule

`default_nettype wire

[rtl/brs_ctrl.sv]
`default_nettype none

module brs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire brs_pkg::brs_stat_t stat_i,
  output      brs_pkg::brs_ctl_t  ctl_o
);

  import brs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REPLY
  } state_e;

  state_e state_q;
  state_e state_d;

  // Next state and command decode
  always_comb begin
    state_d        = state_q;
    ctl_o          = '0;
    ctl_o.scanning = (state_q == S_SCAN);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          state_d      = stat_i.in_direct ? S_REPLY : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.cmd == CMD_ADD && stat_i.slot_free) begin
          ctl_o.add_found = 1'b1;
          state_d         = S_REPLY;
        end else begin
          // a resending slot waits for room in the output register
          ctl_o.step = !stat_i.need_emit || stat_i.can_emit;
          if (ctl_o.step && stat_i.idx_last) begin
            state_d = S_REPLY;
          end
        end
      end
      S_REPLY: begin
        if (stat_i.can_emit) begin
          ctl_o.reply = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // A resend beat is only committed when the output register has room
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.step && stat_i.need_emit) |-> stat_i.can_emit)
    else $error("resend committed into a full output register");

  // An accepted direct command moves to its reply state and takes no new beat there
  a_accept_after_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.accept && stat_i.in_direct) |=> (state_q == S_REPLY) && !ctl_o.accept)
    else $error("direct command skipped its reply");

endmodule

`default_nettype wire

[rtl/backoff_retry_scheduler_unit.sv]
// Exponential backoff retry timer table.
//
// Input channel (in_valid_i / in_stall_o) takes one command beat: add, remove,
// one-second tick or clear. Output channel (out_valid_o / out_stall_i) returns
// result beats; last_o marks the final beat of each command. A tick returns
// one resend beat per expiring slot, in ascending slot order, then a tick-done
// beat with the count.
//
// Remove and a rejected add skip the slot scan and go straight to the reply.
// Add, tick and clear walk the slot table one slot per cycle through the read
// port of the slot RAM while no resend waits for output room (an add stops at
// the first free slot). One command is worked on at a time; in_stall_o is high
// from the accepting edge until the final beat has been loaded.
//
// A stalled output holds its beat; a tick scan pauses on a slot that needs to
// resend until the output register frees up, so no beat is dropped.
// Reset empties the table and clears the seconds counter; no clearing pass.

`default_nettype none

module backoff_retry_scheduler_unit #(
  parameter int ENTRIES       = brs_pkg::ENTRIES_DEF,
  parameter int INTERVAL_BITS = brs_pkg::INTERVAL_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic [brs_pkg::CMD_W-1:0]        cmd_i,
  input  wire logic [brs_pkg::HANDLE_W-1:0]     message_handle_i,
  input  wire logic [brs_pkg::FIELD_IVL_W-1:0]  start_interval_i,
  input  wire logic [brs_pkg::FIELD_IVL_W-1:0]  interval_limit_i,
  input  wire logic [brs_pkg::SLOT_W-1:0]       target_slot_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic [brs_pkg::KIND_W-1:0]       kind_o,
  output      logic [brs_pkg::STATUS_W-1:0]     status_o,
  output      logic [brs_pkg::SLOT_W-1:0]       slot_o,
  output      logic [brs_pkg::HANDLE_W-1:0]     resend_handle_o,
  output      logic [brs_pkg::RETRY_W-1:0]      retry_number_o,
  output      logic                             retired_o,
  output      logic [brs_pkg::TALLY_W-1:0]      tally_o,
  output      logic                             last_o
);

  import brs_pkg::*;

  brs_ctl_t  ctl;
  brs_stat_t stat;

  // Sequencer
  brs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .ctl_o     (ctl)
  );

  // Slot table, timers and result register
  brs_datapath #(
    .ENTRIES      (ENTRIES),
    .INTERVAL_BITS(INTERVAL_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd_i),
    .message_handle_i(message_handle_i),
    .start_interval_i(start_interval_i),
    .interval_limit_i(interval_limit_i),
    .target_slot_i   (target_slot_i),
    .ctl_i           (ctl),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .resend_handle_o (resend_handle_o),
    .retry_number_o  (retry_number_o),
    .retired_o       (retired_o),
    .tally_o         (tally_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire
